// File: rtl/mmac_pkg.sv
// Shared constants, types and channel scan helpers for the moving average calibrator.
`timescale 1ns / 1ps
`default_nettype none

package mmac_pkg;

    localparam int CHANNELS       = 6;
    localparam int CH_BITS        = 3;
    localparam int LOW_CHANNELS   = 4;
    localparam int MASK_BITS      = 4;
    localparam int CAL_BITS       = 64;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int IN_SAMPLE_BITS = 10;
    localparam int AVG_BITS       = 10;
    localparam int VALUE_BITS     = 16;
    localparam int GAIN_BITS      = 16;

    localparam int WINDOW_DEF      = 16;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int FULL_SCALE_DEF  = 1023;

    localparam logic [CFG_IDX_BITS-1:0] REG_MASK      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAL_FIRST = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAL_LAST  = 3'd6;

    typedef logic [CH_BITS-1:0]   chan_t;
    typedef logic [MASK_BITS-1:0] mask_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] max;
        logic signed [VALUE_BITS-1:0] min;
        logic signed [VALUE_BITS-1:0] offset;
        logic [GAIN_BITS-1:0]         gain;
    } cal_t;

    localparam chan_t LAST_CHANNEL  = chan_t'(CHANNELS - 1);
    localparam chan_t FIRST_FIXED   = chan_t'(LOW_CHANNELS);

    // Highest enabled low channel, else the first always-on channel.
    function automatic chan_t start_channel(input mask_t mask);
        chan_t pick;
        pick = FIRST_FIXED;
        for (int i = 0; i < LOW_CHANNELS; i++) begin
            if (mask[i]) begin
                pick = chan_t'(i);
            end
        end
        return pick;
    endfunction

    // Next active channel in ascending scan order, wrapping after the top channel.
    function automatic chan_t next_chan(input chan_t ch, input mask_t mask);
        chan_t c0;
        chan_t pick;
        c0   = (ch == LAST_CHANNEL) ? '0 : chan_t'(ch + 3'd1);
        pick = (c0 >= FIRST_FIXED) ? c0 : FIRST_FIXED;
        for (int i = LOW_CHANNELS - 1; i >= 0; i--) begin
            if (mask[i] && (chan_t'(i) >= c0)) begin
                pick = chan_t'(i);
            end
        end
        return pick;
    endfunction

    // Next lower active channel; only used when one exists.
    function automatic chan_t prev_chan(input chan_t ch, input mask_t mask);
        chan_t pick;
        pick = (ch == LAST_CHANNEL) ? FIRST_FIXED : ch;
        if (ch != LAST_CHANNEL) begin
            for (int i = 0; i < LOW_CHANNELS; i++) begin
                if (mask[i] && (chan_t'(i) < ch)) begin
                    pick = chan_t'(i);
                end
            end
        end
        return pick;
    endfunction

    // True when no active channel lies below this one.
    function automatic logic is_last(input chan_t ch, input mask_t mask);
        logic none_below;
        none_below = (ch <= FIRST_FIXED);
        for (int i = 0; i < LOW_CHANNELS; i++) begin
            if (mask[i] && (chan_t'(i) < ch)) begin
                none_below = 1'b0;
            end
        end
        return none_below;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mmac_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mmac_ram #(
    parameter int WIDTH     = mmac_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH     = mmac_pkg::CHANNELS * mmac_pkg::WINDOW_DEF,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/multichannel_moving_average_calibrator_top.sv
// Top level of the six-channel moving average calibrator.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted sample belongs to the current scan channel: the oldest ring entry is first
// read from the sample RAM, then the channel's running sum is updated and the new sample is
// written back. When the sample closes a scan round with full rings, the block then produces
// one calibrated word per active channel (two to six), highest channel first, each word
// passing through the AVG, GAIN, SCALE, OFFS and CLAMP states and waiting in CLAMP while a
// held output word is not taken by m_ready. The one shared multiplier runs the window
// division, the gain product and the full-scale division by reciprocal multiplication, one
// after another for each word. The input is not ready while a sample is being worked on.
// The sample RAM starts undefined and needs no clearing pass.
module multichannel_moving_average_calibrator_top #(
    parameter int WINDOW      = mmac_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mmac_pkg::SAMPLE_BITS_DEF,
    parameter int FULL_SCALE  = mmac_pkg::FULL_SCALE_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [mmac_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [mmac_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [mmac_pkg::IN_SAMPLE_BITS-1:0]     s_sample,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [mmac_pkg::CH_BITS-1:0]                 m_channel,
    output logic [mmac_pkg::AVG_BITS-1:0]                m_average,
    output logic signed [mmac_pkg::VALUE_BITS-1:0]       m_value,
    output logic                                         m_last
);

    localparam int POS_BITS   = $clog2(WINDOW);
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int PROD_BITS  = SAMPLE_BITS + mmac_pkg::GAIN_BITS;
    localparam int MUL_A_BITS = PROD_BITS;
    localparam int MUL_B_BITS = PROD_BITS + 1;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    localparam int L_W = $clog2(WINDOW);
    localparam int S_W = SUM_BITS + L_W;
    localparam longint unsigned M_W = ((64'd1 << S_W) + WINDOW - 1) / WINDOW;

    localparam int L_FS = $clog2(FULL_SCALE);
    localparam int S_FS = PROD_BITS + L_FS;
    localparam longint unsigned M_FS = ((64'd1 << S_FS) + FULL_SCALE - 1) / FULL_SCALE;

    localparam int Q_BITS = PROD_BITS - L_FS + 1;
    localparam int V_BITS = ((Q_BITS > mmac_pkg::VALUE_BITS) ? Q_BITS : mmac_pkg::VALUE_BITS) + 2;

    localparam int RAM_DEPTH = mmac_pkg::CHANNELS * WINDOW;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_AVG   = 3'd2;
    localparam logic [2:0] ST_GAIN  = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_OFFS  = 3'd5;
    localparam logic [2:0] ST_CLAMP = 3'd6;

    logic [2:0]              state_reg;
    mmac_pkg::mask_t         mask_reg;
    mmac_pkg::cal_t          cal_reg [mmac_pkg::CHANNELS];
    logic [SUM_BITS-1:0]     sum_reg [mmac_pkg::CHANNELS];
    mmac_pkg::chan_t         chan_reg;
    logic [POS_BITS-1:0]     pos_reg;
    logic                    full_reg;
    mmac_pkg::chan_t         emit_ch_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [MUL_P_BITS-1:0]   prod_reg;
    logic [SAMPLE_BITS-1:0]  avg_reg;
    logic signed [V_BITS-1:0] v_reg;

    logic                    m_valid_reg;
    mmac_pkg::chan_t         m_channel_reg;
    logic [mmac_pkg::AVG_BITS-1:0]   m_average_reg;
    logic signed [mmac_pkg::VALUE_BITS-1:0] m_value_reg;
    logic                    m_last_reg;

    mmac_pkg::chan_t         sum_idx;
    logic [SUM_BITS-1:0]     sum_rd;
    mmac_pkg::cal_t          cal_sel;
    logic [SAMPLE_BITS-1:0]  ram_rdata;
    logic [RAM_AW-1:0]       ram_addr;
    logic                    accept;
    logic [SUM_BITS-1:0]     sum_next;
    mmac_pkg::chan_t         chan_next;
    logic [POS_BITS-1:0]     pos_next;
    logic                    full_next;
    logic                    emit_now;
    logic [MUL_A_BITS-1:0]   mul_a;
    logic [MUL_B_BITS-1:0]   mul_b;
    logic [MUL_P_BITS-1:0]   prod_next;
    logic [SAMPLE_BITS-1:0]  avg_slice;
    logic [Q_BITS-1:0]       quot;
    logic signed [V_BITS-1:0] v_next;
    logic signed [V_BITS-1:0] max_ext;
    logic signed [V_BITS-1:0] min_ext;
    logic signed [mmac_pkg::VALUE_BITS-1:0] value_next;
    logic                    last_now;
    logic                    out_load;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign sum_idx = (state_reg == ST_UPD) ? chan_reg : emit_ch_reg;
    assign sum_rd  = sum_reg[sum_idx];
    assign cal_sel = cal_reg[emit_ch_reg];

    assign ram_addr = RAM_AW'(RAM_AW'(chan_reg) * RAM_AW'(WINDOW)) + RAM_AW'(pos_reg);

    mmac_ram #(
        .WIDTH     (SAMPLE_BITS),
        .DEPTH     (RAM_DEPTH),
        .ADDR_BITS (RAM_AW)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (state_reg == ST_UPD),
        .waddr (ram_addr),
        .wdata (sample_reg),
        .re    (accept),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Running sum update and scan advance for the sample in hand.
    always_comb begin
        sum_next  = sum_rd - (full_reg ? SUM_BITS'(ram_rdata) : '0) + SUM_BITS'(sample_reg);
        chan_next = mmac_pkg::next_chan(chan_reg, mask_reg);
        pos_next  = pos_reg;
        full_next = full_reg;
        emit_now  = 1'b0;
        if (chan_reg == mmac_pkg::LAST_CHANNEL) begin
            if (pos_reg == POS_BITS'(WINDOW - 1)) begin
                pos_next  = '0;
                full_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
            emit_now = full_next;
        end
    end

    // Shared multiplier: window reciprocal, gain, then full-scale reciprocal.
    always_comb begin
        case (state_reg)
            ST_AVG: begin
                mul_a = MUL_A_BITS'(sum_rd);
                mul_b = MUL_B_BITS'(M_W);
            end
            ST_GAIN: begin
                mul_a = MUL_A_BITS'(avg_slice);
                mul_b = MUL_B_BITS'(cal_sel.gain);
            end
            default: begin
                mul_a = prod_reg[MUL_A_BITS-1:0];
                mul_b = MUL_B_BITS'(M_FS);
            end
        endcase
        prod_next = MUL_P_BITS'(mul_a) * MUL_P_BITS'(mul_b);
    end

    assign avg_slice = prod_reg[S_W +: SAMPLE_BITS];
    assign quot      = prod_reg[S_FS +: Q_BITS];
    assign v_next    = $signed(V_BITS'(quot)) + V_BITS'($signed(cal_sel.offset));
    assign max_ext   = V_BITS'($signed(cal_sel.max));
    assign min_ext   = V_BITS'($signed(cal_sel.min));

    always_comb begin
        if (v_reg > max_ext) begin
            value_next = cal_sel.max;
        end else if (v_reg < min_ext) begin
            value_next = cal_sel.min;
        end else begin
            value_next = v_reg[mmac_pkg::VALUE_BITS-1:0];
        end
    end

    assign last_now = mmac_pkg::is_last(emit_ch_reg, mask_reg);
    assign out_load = (state_reg == ST_CLAMP) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mask_reg    <= '0;
            chan_reg    <= mmac_pkg::start_channel('0);
            pos_reg     <= '0;
            full_reg    <= 1'b0;
            emit_ch_reg <= mmac_pkg::LAST_CHANNEL;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < mmac_pkg::CHANNELS; i++) begin
                cal_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    sum_reg[chan_reg] <= sum_next;
                    chan_reg          <= chan_next;
                    pos_reg           <= pos_next;
                    full_reg          <= full_next;
                    emit_ch_reg       <= mmac_pkg::LAST_CHANNEL;
                    state_reg         <= emit_now ? ST_AVG : ST_IDLE;
                end
                ST_AVG:   state_reg <= ST_GAIN;
                ST_GAIN:  state_reg <= ST_SCALE;
                ST_SCALE: state_reg <= ST_OFFS;
                ST_OFFS:  state_reg <= ST_CLAMP;
                ST_CLAMP: begin
                    if (out_load) begin
                        if (last_now) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            emit_ch_reg <= mmac_pkg::prev_chan(emit_ch_reg, mask_reg);
                            state_reg   <= ST_AVG;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cfg_wr_en) begin
                if (cfg_index == mmac_pkg::REG_MASK) begin
                    mask_reg <= cfg_wdata[mmac_pkg::MASK_BITS-1:0];
                    chan_reg <= mmac_pkg::start_channel(cfg_wdata[mmac_pkg::MASK_BITS-1:0]);
                end else if (cfg_index inside {[mmac_pkg::REG_CAL_FIRST:mmac_pkg::REG_CAL_LAST]})
                begin
                    cal_reg[cfg_index - mmac_pkg::REG_CAL_FIRST] <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= SAMPLE_BITS'(s_sample);
        end
        if ((state_reg == ST_AVG) || (state_reg == ST_GAIN) || (state_reg == ST_SCALE)) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_GAIN) begin
            avg_reg <= avg_slice;
        end
        if (state_reg == ST_OFFS) begin
            v_reg <= v_next;
        end
        if (out_load) begin
            m_channel_reg <= emit_ch_reg;
            m_average_reg <= mmac_pkg::AVG_BITS'(avg_reg);
            m_value_reg   <= value_next;
            m_last_reg    <= last_now;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_channel = m_channel_reg;
    assign m_average = m_average_reg;
    assign m_value   = m_value_reg;
    assign m_last    = m_last_reg;

endmodule

`default_nettype wire

// File: rtl/mmac_checker.sv
// Port-level checker for the moving average calibrator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module mmac_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                cfg_wr_en,
    input wire logic [mmac_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input wire logic [mmac_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic [mmac_pkg::IN_SAMPLE_BITS-1:0] s_sample,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic [mmac_pkg::CH_BITS-1:0]        m_channel,
    input wire logic [mmac_pkg::AVG_BITS-1:0]       m_average,
    input wire logic signed [mmac_pkg::VALUE_BITS-1:0] m_value,
    input wire logic                                m_last
);

    logic unused_ok;
    assign unused_ok = cfg_wr_en ^ (|cfg_index) ^ (|cfg_wdata) ^ (|s_sample);

    // A held output word keeps its contents until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_channel) && $stable(m_average)
            && $stable(m_value) && $stable(m_last))
        else $error("Output word changed while stalled.");

    // Channel numbers stay within the six scan channels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_channel <= mmac_pkg::LAST_CHANNEL))
        else $error("Output channel out of range.");

    // The top channel is always followed by an always-on channel, so it never ends a round.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> (m_channel != mmac_pkg::LAST_CHANNEL))
        else $error("Round ended on the top channel.");

    // The input is not ready in the cycle after a sample is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input ready right after a sample was taken.");

    // Reset leaves no output word pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Output valid right after reset.");

endmodule

bind multichannel_moving_average_calibrator_top mmac_checker u_mmac_checker (.*);

`default_nettype wire
